FILE: rtl/core/bcm_pkg.sv
// Shared constants and types of the binomial coefficient mod prime unit.
// No dependencies; every other file of the block imports this package.
package bcm_pkg;

  localparam int VALUE_W = 30;
  localparam int COUNT_W = 12;
  localparam int unsigned PRIME = 1000000007;
  localparam logic [VALUE_W-1:0] PRIME_MOD = VALUE_W'(PRIME);

  localparam int TABLE_SIZE_DEFAULT = 4096;

  // Pipeline depth of the modular multiplier.
  localparam int MM_LAT = 5;

  // Result queue; a power of two so the pointers wrap on their own.
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic   valid;
    value_t a;
    value_t b;
  } mm_req_t;

  typedef struct packed {
    logic   valid;
    value_t value;
  } mm_resp_t;

endpackage

FILE: rtl/core/bcm_query_if.sv
// Query channel: valid/ready handshake carrying n and k.
// Depends on bcm_pkg for the field width.
interface bcm_query_if import bcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] top_count;
  logic [COUNT_W-1:0] choose_count;

  modport source(output valid, output top_count, output choose_count, input ready);
  modport sink(input valid, input top_count, input choose_count, output ready);
endinterface

FILE: rtl/core/bcm_result_if.sv
// Result channel: valid/ready handshake carrying C(n,k) mod p.
// Depends on bcm_pkg for the value type.
interface bcm_result_if import bcm_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t binomial_value;

  modport source(output valid, output binomial_value, input ready);
  modport sink(input valid, input binomial_value, output ready);
endinterface

FILE: rtl/core/bcm_mulmod.sv
// Five-stage pipelined multiplier modulo the prime, using Barrett reduction.
// Depends on bcm_pkg for the prime, the value width and the request types.
module bcm_mulmod import bcm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mm_req_t  req,
  output mm_resp_t resp
);

  localparam logic [63:0] BARRETT_FULL = (64'd1 << (2 * VALUE_W)) / 64'(PRIME);
  localparam logic [VALUE_W:0] BARRETT_M = BARRETT_FULL[VALUE_W:0];
  localparam logic [31:0] P1 = 32'(PRIME);
  localparam logic [31:0] P2 = 32'(2 * PRIME);

  logic [2*VALUE_W-1:0]   prod_full;
  logic [2*VALUE_W+1:0]   q2_full;
  logic [2*VALUE_W:0]     q3p_full;

  logic                   v1, v2, v3, v4, v5;
  logic [2*VALUE_W-1:0]   s1_prod;
  logic [2*VALUE_W+1:0]   s2_q2;
  logic [31:0]            s2_x;
  logic [31:0]            s3_q3p;
  logic [31:0]            s3_x;
  logic [31:0]            s4_r;
  value_t                 s5_val;
  value_t                 reduced;

  assign prod_full = req.a * req.b;
  assign q2_full   = s1_prod[2*VALUE_W-1:VALUE_W-1] * BARRETT_M;
  assign q3p_full  = s2_q2[2*VALUE_W+1:VALUE_W+1] * PRIME_MOD;

  // The quotient estimate is short by at most two, so the remainder is
  // below three times the prime and two conditional subtractions finish it.
  always_comb begin
    if (s4_r >= P2) begin
      reduced = VALUE_W'(s4_r - P2);
    end else if (s4_r >= P1) begin
      reduced = VALUE_W'(s4_r - P1);
    end else begin
      reduced = VALUE_W'(s4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod <= prod_full;
    s2_q2   <= q2_full;
    s2_x    <= s1_prod[31:0];
    s3_q3p  <= q3p_full[31:0];
    s3_x    <= s2_x;
    s4_r    <= s3_x - s3_q3p;
    s5_val  <= reduced;
  end

  assign resp = '{valid: v5, value: s5_val};

endmodule

FILE: rtl/core/bcm_tables.sv
// Table memories: factorial and inverse packed in one word, and the inverse
// factorial with two read ports. Depends on bcm_pkg for the value type.
module bcm_tables import bcm_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
  input  value_t                        wr_fac,
  input  value_t                        wr_inv,
  input  value_t                        wr_finv,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_a_addr,
  output value_t                        rd_a_fac,
  output value_t                        rd_a_inv,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_b_addr,
  output value_t                        rd_b_finv,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_c_addr,
  output value_t                        rd_c_finv
);

  logic [2*VALUE_W-1:0] fac_inv_mem [TABLE_SIZE];
  value_t               finv_mem [TABLE_SIZE];
  logic [2*VALUE_W-1:0] rd_a_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fac_inv_mem[wr_addr] <= {wr_fac, wr_inv};
      finv_mem[wr_addr]    <= wr_finv;
    end
    rd_a_word <= fac_inv_mem[rd_a_addr];
    rd_b_finv <= finv_mem[rd_b_addr];
    rd_c_finv <= finv_mem[rd_c_addr];
  end

  assign rd_a_fac = rd_a_word[2*VALUE_W-1:VALUE_W];
  assign rd_a_inv = rd_a_word[VALUE_W-1:0];

endmodule

FILE: rtl/core/bcm_divider.sv
// Restoring divider of the fixed prime by a table index, one quotient bit
// per cycle. Depends on bcm_pkg for the prime and the value width.
module bcm_divider import bcm_pkg::*; #(
  parameter int IDX_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] divisor,
  output logic             done,
  output value_t           quotient,
  output logic [IDX_W-1:0] remainder
);

  localparam int STEP_W = $clog2(VALUE_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  dvs;
  logic [IDX_W:0]    shifted;
  logic [IDX_W:0]    diff;
  logic              ge;

  // The dividend bits are shifted out of the top of the quotient register
  // while the quotient bits enter at the bottom.
  assign shifted = {remainder, quotient[VALUE_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(VALUE_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step      <= '0;
      quotient  <= PRIME_MOD;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      step      <= step + STEP_W'(1);
      quotient  <= {quotient[VALUE_W-2:0], ge};
      remainder <= ge ? diff[IDX_W-1:0] : shifted[IDX_W-1:0];
    end
  end

endmodule

FILE: rtl/core/bcm_builder.sv
// Sequencer of the build pass that fills the tables after reset.
// Depends on bcm_pkg and instantiates bcm_divider.
module bcm_builder import bcm_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          building,
  output mm_req_t                       mm_req,
  input  mm_resp_t                      mm_resp,
  output logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  input  value_t                        rd_inv,
  output logic                          wr_en,
  output logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
  output value_t                        wr_fac,
  output value_t                        wr_inv,
  output value_t                        wr_finv
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  typedef enum logic [8:0] {
    ST_INIT0  = 9'b000000001,
    ST_INIT1  = 9'b000000010,
    ST_DSTART = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_MFAC   = 9'b000010000,
    ST_MINV   = 9'b000100000,
    ST_MFINV  = 9'b001000000,
    ST_WRITE  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } build_state_t;

  build_state_t     state, state_next;
  logic             mm_sent;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rem_reg;
  value_t           quo_reg;
  value_t           fac_run;
  value_t           inv_cur;
  value_t           finv_run;

  logic             div_start;
  logic             div_done;
  value_t           div_quo;
  logic [IDX_W-1:0] div_rem;

  bcm_divider #(.IDX_W(IDX_W)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .divisor   (idx),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign building = (state != ST_DONE);
  assign rd_addr  = rem_reg;

  always_comb begin
    state_next = state;
    mm_req     = '{valid: 1'b0, a: '0, b: '0};
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_fac     = fac_run;
    wr_inv     = inv_cur;
    wr_finv    = finv_run;
    div_start  = 1'b0;
    case (state)
      ST_INIT0: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_fac     = VALUE_W'(1);
        wr_inv     = '0;
        wr_finv    = VALUE_W'(1);
        state_next = ST_INIT1;
      end
      ST_INIT1: begin
        wr_en      = 1'b1;
        wr_addr    = IDX_W'(1);
        wr_fac     = VALUE_W'(1);
        wr_inv     = VALUE_W'(1);
        wr_finv    = VALUE_W'(1);
        state_next = (TABLE_SIZE > 2) ? ST_DSTART : ST_DONE;
      end
      ST_DSTART: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MFAC;
        end
      end
      ST_MFAC: begin
        mm_req = '{valid: !mm_sent, a: fac_run, b: VALUE_W'(idx)};
        if (mm_resp.valid) begin
          state_next = ST_MINV;
        end
      end
      ST_MINV: begin
        mm_req = '{valid: !mm_sent, a: rd_inv, b: quo_reg};
        if (mm_resp.valid) begin
          state_next = ST_MFINV;
        end
      end
      ST_MFINV: begin
        mm_req = '{valid: !mm_sent, a: finv_run, b: inv_cur};
        if (mm_resp.valid) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = (idx == LAST_IDX) ? ST_DONE : ST_DSTART;
      end
      ST_DONE: begin
        state_next = ST_DONE;
      end
      default: begin
        state_next = ST_INIT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT0;
      mm_sent <= 1'b0;
    end else begin
      state <= state_next;
      if (mm_resp.valid) begin
        mm_sent <= 1'b0;
      end else if (mm_req.valid) begin
        mm_sent <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_INIT1: begin
        idx      <= IDX_W'(2);
        fac_run  <= VALUE_W'(1);
        finv_run <= VALUE_W'(1);
      end
      ST_DIV: begin
        if (div_done) begin
          rem_reg <= div_rem;
          quo_reg <= div_quo;
        end
      end
      ST_MFAC: begin
        if (mm_resp.valid) begin
          fac_run <= mm_resp.value;
        end
      end
      ST_MINV: begin
        // The product is never zero here, so the difference stays in range.
        if (mm_resp.valid) begin
          inv_cur <= PRIME_MOD - mm_resp.value;
        end
      end
      ST_MFINV: begin
        if (mm_resp.valid) begin
          finv_run <= mm_resp.value;
        end
      end
      ST_WRITE: begin
        idx <= idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/binomial_coefficient_mod_prime_unit.sv
// Top level of the binomial coefficient mod prime unit: query pipeline and
// result queue. Depends on bcm_pkg, both channel interfaces, and the modules.
//
// After reset the unit builds its factorial, inverse and inverse-factorial
// tables (4096 entries at the default TABLE_SIZE), one entry at a time; each
// entry needs a one-bit-per-cycle division of the prime by the index and three
// passes through the shared modular multiplier. No query is taken during the
// build pass. Afterwards one query is accepted every cycle as long as fewer
// than 16 are outstanding; each result passes one table read, then two
// five-stage modular multipliers. A 16-entry result queue decouples the two
// sides, and queries keep being accepted while results wait.
module binomial_coefficient_mod_prime_unit import bcm_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  bcm_query_if.sink   query,
  bcm_result_if.source result
);

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic                  building;
  mm_req_t               bld_req;
  logic [IDX_W-1:0]      bld_rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  value_t                wr_fac, wr_inv, wr_finv;

  logic [IDX_W-1:0]      rd_a_addr, rd_b_addr, rd_c_addr;
  value_t                rd_a_fac, rd_a_inv, rd_b_finv, rd_c_finv;

  logic                  in_fire;
  logic [COUNT_W-1:0]    diff_count;
  logic                  q1_valid;
  logic                  q1_zero;
  value_t                fac_line [MM_LAT];

  mm_req_t               mm_a_req, mm_b_req;
  mm_resp_t              mm_a_resp, mm_b_resp;

  value_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0]      fifo_count;
  logic [OCC_W-1:0]      occ;
  logic                  push, pop;

  bcm_builder #(.TABLE_SIZE(TABLE_SIZE)) u_builder (
    .clk      (clk),
    .rst      (rst),
    .building (building),
    .mm_req   (bld_req),
    .mm_resp  (mm_a_resp),
    .rd_addr  (bld_rd_addr),
    .rd_inv   (rd_a_inv),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_fac   (wr_fac),
    .wr_inv   (wr_inv),
    .wr_finv  (wr_finv)
  );

  bcm_tables #(.TABLE_SIZE(TABLE_SIZE)) u_tables (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_fac    (wr_fac),
    .wr_inv    (wr_inv),
    .wr_finv   (wr_finv),
    .rd_a_addr (rd_a_addr),
    .rd_a_fac  (rd_a_fac),
    .rd_a_inv  (rd_a_inv),
    .rd_b_addr (rd_b_addr),
    .rd_b_finv (rd_b_finv),
    .rd_c_addr (rd_c_addr),
    .rd_c_finv (rd_c_finv)
  );

  bcm_mulmod u_mulmod_a (
    .clk  (clk),
    .rst  (rst),
    .req  (mm_a_req),
    .resp (mm_a_resp)
  );

  bcm_mulmod u_mulmod_b (
    .clk  (clk),
    .rst  (rst),
    .req  (mm_b_req),
    .resp (mm_b_resp)
  );

  // Counting every transaction in flight, not only queued results, keeps the
  // queue from ever overflowing while the pipeline runs without stalls.
  assign query.ready = !building && (occ < OCC_W'(FIFO_DEPTH));
  assign in_fire     = query.valid && query.ready;
  assign diff_count  = query.top_count - query.choose_count;

  assign rd_a_addr = building ? bld_rd_addr : IDX_W'(query.top_count);
  assign rd_b_addr = IDX_W'(query.choose_count);
  assign rd_c_addr = IDX_W'(diff_count);

  // For the special cases every operand is zeroed, since the addresses may
  // then point at entries that the table does not hold.
  assign mm_b_req = '{valid: q1_valid,
                      a: q1_zero ? '0 : rd_b_finv,
                      b: q1_zero ? '0 : rd_c_finv};

  assign mm_a_req = building ? bld_req :
                    mm_req_t'{valid: mm_b_resp.valid, a: fac_line[MM_LAT-1],
                              b: mm_b_resp.value};

  assign push = mm_a_resp.valid && !building;
  assign pop  = result.valid && result.ready;

  assign result.valid          = (fifo_count != '0);
  assign result.binomial_value = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid   <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      occ        <= '0;
    end else begin
      q1_valid <= in_fire;
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fifo_count <= fifo_count + OCC_W'(1);
        2'b01:   fifo_count <= fifo_count - OCC_W'(1);
        default: fifo_count <= fifo_count;
      endcase
      case ({in_fire, pop})
        2'b10:   occ <= occ + OCC_W'(1);
        2'b01:   occ <= occ - OCC_W'(1);
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q1_zero     <= (query.choose_count > query.top_count) ||
                   (32'(query.top_count) >= 32'(TABLE_SIZE));
    fac_line[0] <= q1_zero ? '0 : rd_a_fac;
    for (int j = 1; j < MM_LAT; j++) begin
      fac_line[j] <= fac_line[j-1];
    end
    if (push) begin
      fifo_mem[wr_ptr] <= mm_a_resp.value;
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("outstanding transaction count exceeds the result queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (fifo_count < OCC_W'(FIFO_DEPTH)))
    else $error("result queue written while full");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.binomial_value < PRIME_MOD))
    else $error("result value not reduced below the prime");

  a_build_quiet: assert property (@(posedge clk) disable iff (rst)
    building |-> (occ == '0 && !q1_valid))
    else $error("query in flight while the shared multiplier builds tables");
`endif

endmodule
